FILE: hdl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants
// Opcodes, flag bits and the records that travel down the ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package cia_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned FlagW = 6;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIVU = 5'd3,
    OP_MODU = 5'd4,  OP_MULS = 5'd5,  OP_DIVS = 5'd6,  OP_MODS = 5'd7,
    OP_SHL1 = 5'd8,  OP_SHR1 = 5'd9,  OP_SHL  = 5'd10, OP_SHR  = 5'd11,
    OP_ROL1 = 5'd12, OP_ROR1 = 5'd13, OP_ROL  = 5'd14, OP_ROR  = 5'd15,
    OP_OR   = 5'd16, OP_AND  = 5'd17, OP_XOR  = 5'd18, OP_BSET = 5'd19,
    OP_BCLR = 5'd20, OP_NOT  = 5'd21, OP_INC  = 5'd22, OP_DEC  = 5'd23,
    OP_CMP  = 5'd24, OP_TSTZ = 5'd25, OP_PASS = 5'd26
  } op_t;

  localparam logic [FlagW-1:0] FLAG_ZERO    = 6'b00_0001;
  localparam logic [FlagW-1:0] FLAG_NONZERO = 6'b00_0010;
  localparam logic [FlagW-1:0] FLAG_EQ      = 6'b00_0100;
  localparam logic [FlagW-1:0] FLAG_NE      = 6'b00_1000;
  localparam logic [FlagW-1:0] FLAG_LT      = 6'b01_0000;
  localparam logic [FlagW-1:0] FLAG_GT      = 6'b10_0000;

  // Control and finished results that ride along with the divider data.
  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             want_rem;
    logic             neg;
    logic             dz;
    logic             fvalid;
    logic [FlagW-1:0] flags;
    logic [Width-1:0] res;
  } ctl_t;

  typedef struct packed {
    logic [Width-1:0] rem;
    logic [Width-1:0] dvd;
    logic [Width-1:0] dvs;
  } div_t;

endpackage
`default_nettype wire

FILE: hdl/cia_front.sv
// ----------------------------------------------------------------------------
// cia_front: operand decode stage
// Computes every single-cycle operation and prepares divider operands.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_fire,
  input  wire logic [4:0]               opcode,
  input  wire logic [cia_pkg::Width-1:0] operand_a,
  input  wire logic [cia_pkg::Width-1:0] operand_b,
  output cia_pkg::ctl_t                 ctl,
  output cia_pkg::div_t                 dat
);
  import cia_pkg::*;

  ctl_t             ctl_next;
  div_t             dat_next;
  logic             big;
  logic [4:0]       sh;
  logic [63:0]      rl;
  logic [63:0]      rr;
  logic [Width-1:0] bit_mask;
  logic [Width-1:0] mag_a;
  logic [Width-1:0] mag_b;
  logic             sgn;
  logic             bz;

  always_comb begin
    big      = |operand_b[Width-1:5];
    sh       = operand_b[4:0];
    rl       = {operand_a, operand_a} << sh;
    rr       = {operand_a, operand_a} >> sh;
    bit_mask = {{(Width-1){1'b0}}, 1'b1} << sh;
    mag_a    = operand_a[Width-1] ? (Width'(0) - operand_a) : operand_a;
    mag_b    = operand_b[Width-1] ? (Width'(0) - operand_b) : operand_b;
    bz       = (operand_b == '0);
    sgn      = (opcode == OP_DIVS) || (opcode == OP_MODS);

    ctl_next          = '0;
    ctl_next.valid    = in_fire;
    ctl_next.res      = operand_a;
    ctl_next.want_rem = (opcode == OP_MODU) || (opcode == OP_MODS);
    ctl_next.neg      = (opcode == OP_MODS) ? operand_a[Width-1]
                                            : (operand_a[Width-1] ^ operand_b[Width-1]);
    dat_next.rem      = '0;
    dat_next.dvd      = sgn ? mag_a : operand_a;
    dat_next.dvs      = sgn ? mag_b : operand_b;

    case (opcode)
      OP_ADD:  ctl_next.res = operand_a + operand_b;
      OP_SUB:  ctl_next.res = operand_a - operand_b;
      OP_MUL, OP_MULS: ctl_next.res = operand_a * operand_b;
      OP_DIVU, OP_MODU, OP_DIVS, OP_MODS: begin
        ctl_next.is_div = ~bz;
        ctl_next.dz     = bz;
        ctl_next.res    = '0;
        ctl_next.neg    = sgn & ctl_next.neg;
      end
      OP_SHL1: ctl_next.res = {operand_a[Width-2:0], 1'b0};
      OP_SHR1: ctl_next.res = {1'b0, operand_a[Width-1:1]};
      OP_SHL:  ctl_next.res = big ? '0 : (operand_a << sh);
      OP_SHR:  ctl_next.res = big ? '0 : (operand_a >> sh);
      OP_ROL1: ctl_next.res = {operand_a[Width-2:0], operand_a[Width-1]};
      OP_ROR1: ctl_next.res = {operand_a[0], operand_a[Width-1:1]};
      OP_ROL:  ctl_next.res = rl[63:32];
      OP_ROR:  ctl_next.res = rr[31:0];
      OP_OR:   ctl_next.res = operand_a | operand_b;
      OP_AND:  ctl_next.res = operand_a & operand_b;
      OP_XOR:  ctl_next.res = operand_a ^ operand_b;
      OP_BSET: ctl_next.res = big ? operand_a : (operand_a | bit_mask);
      OP_BCLR: ctl_next.res = big ? operand_a : (operand_a & ~bit_mask);
      OP_NOT:  ctl_next.res = ~operand_a;
      OP_INC:  ctl_next.res = operand_a + Width'(1);
      OP_DEC:  ctl_next.res = operand_a - Width'(1);
      OP_CMP: begin
        ctl_next.fvalid = 1'b1;
        ctl_next.flags  = ((operand_a == operand_b) ? FLAG_EQ : FLAG_NE)
                        | ((operand_a < operand_b) ? FLAG_LT : '0)
                        | ((operand_a > operand_b) ? FLAG_GT : '0);
      end
      OP_TSTZ: begin
        ctl_next.fvalid = 1'b1;
        ctl_next.flags  = (operand_a == '0) ? FLAG_ZERO : FLAG_NONZERO;
      end
      OP_PASS: ctl_next.res = operand_b;
      default: ctl_next.res = operand_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl <= ctl_next;
      dat <= dat_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cia_div_cell.sv
// ----------------------------------------------------------------------------
// cia_div_cell: one restoring division step
// Develops one quotient bit and hands the partial state to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module cia_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire cia_pkg::ctl_t ctl_in,
  input  wire cia_pkg::div_t dat_in,
  output cia_pkg::ctl_t      ctl,
  output cia_pkg::div_t      dat
);
  import cia_pkg::*;

  logic [Width:0] trial;
  logic [Width:0] diff;
  div_t           dat_next;

  always_comb begin
    trial        = {dat_in.rem, dat_in.dvd[Width-1]};
    diff         = trial - {1'b0, dat_in.dvs};
    dat_next.dvs = dat_in.dvs;
    // A non-negative difference means the divisor fits: keep it, quotient bit 1.
    dat_next.rem = diff[Width] ? trial[Width-1:0] : diff[Width-1:0];
    dat_next.dvd = {dat_in.dvd[Width-2:0], ~diff[Width]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl <= ctl_in;
      dat <= dat_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cpu_integer_alu.sv
// ----------------------------------------------------------------------------
// cpu_integer_alu: pipelined 32-bit integer ALU
// Arithmetic, logic, shift, compare and pipelined divide in one stream.
// ----------------------------------------------------------------------------
// Usage: present opcode, operand_a and operand_b with in_valid; an operation
// transfers when in_valid and in_ready are both high. Each operation yields
// exactly one result (result, flags, flags_valid, divide_by_zero) on the
// output channel, transferred when out_valid and out_ready are both high.
// Every opcode passes through the same path: one decode stage, a chain of 32
// division cells that each develop one quotient bit, and one output stage.
// Throughput is one operation per cycle. The whole pipeline advances while
// the output register is empty or being taken; when the receiver stalls with
// a result waiting, the pipeline holds and in_ready drops. Results come out
// in order. Reset empties the pipeline; no operation is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_integer_alu (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [4:0]                opcode,
  input  wire logic [cia_pkg::Width-1:0] operand_a,
  input  wire logic [cia_pkg::Width-1:0] operand_b,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [cia_pkg::Width-1:0]      result,
  output logic [cia_pkg::FlagW-1:0]      flags,
  output logic                           flags_valid,
  output logic                           divide_by_zero
);
  import cia_pkg::*;

  localparam int unsigned Cells = Width;

  ctl_t             ctl_s [Cells+1];
  div_t             dat_s [Cells+1];
  logic             en;
  logic [Width-1:0] raw;
  logic [Width-1:0] fixed;
  logic [Width-1:0] res_next;

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  cia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_fire   (in_valid & en),
    .opcode    (opcode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .ctl       (ctl_s[0]),
    .dat       (dat_s[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    cia_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (ctl_s[i]),
      .dat_in (dat_s[i]),
      .ctl    (ctl_s[i+1]),
      .dat    (dat_s[i+1])
    );
  end

  always_comb begin
    raw      = ctl_s[Cells].want_rem ? dat_s[Cells].rem : dat_s[Cells].dvd;
    fixed    = ctl_s[Cells].neg ? (Width'(0) - raw) : raw;
    res_next = ctl_s[Cells].is_div ? fixed : ctl_s[Cells].res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid      <= ctl_s[Cells].valid;
      result         <= res_next;
      flags          <= ctl_s[Cells].flags;
      flags_valid    <= ctl_s[Cells].fvalid;
      divide_by_zero <= ctl_s[Cells].dz;
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for cpu_integer_alu
// A directed table of operations, some with typed-in results, is followed by
// random operations. Every result transfer is checked against an in-order
// queue filled from the typed-in results or by a behavioral model of the ALU.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import cia_pkg::*;

  typedef struct packed {
    logic [Width-1:0] res;
    logic [FlagW-1:0] flg;
    logic             fv;
    logic             dz;
  } alu_out_t;

  typedef struct {
    logic [4:0]       op;
    logic [Width-1:0] a;
    logic [Width-1:0] b;
    logic             known;
    alu_out_t         want;
  } row_t;

  localparam int unsigned NumRandom = 1750;
  localparam int unsigned Limit     = 400000;
  localparam logic [Width-1:0] MinInt = 32'h8000_0000;
  localparam logic [Width-1:0] MaxInt = 32'h7FFF_FFFF;
  localparam logic [Width-1:0] Ones   = 32'hFFFF_FFFF;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [4:0]       opcode = '0;
  logic [Width-1:0] operand_a = '0;
  logic [Width-1:0] operand_b = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [Width-1:0] result;
  logic [FlagW-1:0] flags;
  logic             flags_valid;
  logic             divide_by_zero;

  alu_out_t pending_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          sending_done = 1'b0;
  row_t        dir_rows[$];

  cpu_integer_alu uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .result(result), .flags(flags), .flags_valid(flags_valid),
    .divide_by_zero(divide_by_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [Width-1:0] abs_val(logic [Width-1:0] v);
    return v[Width-1] ? -v : v;
  endfunction

  function automatic alu_out_t alu_predict(logic [4:0] op, logic [Width-1:0] a,
                                           logic [Width-1:0] b);
    alu_out_t o;
    logic [Width-1:0] q;
    logic [Width-1:0] r;
    logic [4:0] n;
    o = '{res: a, flg: '0, fv: 1'b0, dz: 1'b0};
    n = b[4:0];
    case (op)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL, OP_MULS: o.res = a * b;
      OP_DIVU, OP_MODU, OP_DIVS, OP_MODS: begin
        if (b == '0) begin
          o.res = '0;
          o.dz = 1'b1;
        end else if (op == OP_DIVU) begin
          o.res = a / b;
        end else if (op == OP_MODU) begin
          o.res = a % b;
        end else begin
          q = abs_val(a) / abs_val(b);
          r = abs_val(a) % abs_val(b);
          if (op == OP_DIVS) o.res = (a[Width-1] != b[Width-1]) ? -q : q;
          else o.res = a[Width-1] ? -r : r;
        end
      end
      OP_SHL1: o.res = a << 1;
      OP_SHR1: o.res = a >> 1;
      OP_SHL: o.res = (b >= 32) ? '0 : a << b[4:0];
      OP_SHR: o.res = (b >= 32) ? '0 : a >> b[4:0];
      OP_ROL1: o.res = {a[Width-2:0], a[Width-1]};
      OP_ROR1: o.res = {a[0], a[Width-1:1]};
      OP_ROL: o.res = (a << n) | ((n == 0) ? '0 : a >> (6'd32 - n));
      OP_ROR: o.res = (a >> n) | ((n == 0) ? '0 : a << (6'd32 - n));
      OP_OR: o.res = a | b;
      OP_AND: o.res = a & b;
      OP_XOR: o.res = a ^ b;
      OP_BSET: o.res = (b >= 32) ? a : a | (32'd1 << n);
      OP_BCLR: o.res = (b >= 32) ? a : a & ~(32'd1 << n);
      OP_NOT: o.res = ~a;
      OP_INC: o.res = a + 1;
      OP_DEC: o.res = a - 1;
      OP_CMP: begin
        o.flg = (a == b) ? FLAG_EQ : FLAG_NE;
        if (a < b) o.flg |= FLAG_LT;
        if (a > b) o.flg |= FLAG_GT;
        o.fv = 1'b1;
      end
      OP_TSTZ: begin
        o.flg = (a == '0) ? FLAG_ZERO : FLAG_NONZERO;
        o.fv = 1'b1;
      end
      OP_PASS: o.res = b;
      default: ;
    endcase
    return o;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [Width-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return Ones;
      2: return MinInt;
      3: return MaxInt;
      4: return $urandom_range(40);
      5: return -$urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(logic [4:0] op, logic [Width-1:0] a, logic [Width-1:0] b,
                         logic known, alu_out_t want);
    row_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.known = known;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic send_op(logic [4:0] op, logic [Width-1:0] a, logic [Width-1:0] b);
    opcode <= op;
    operand_a <= a;
    operand_b <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender: inputs change only at the rising edge, after the transfer.
  initial begin
    alu_out_t w;
    int unsigned g;
    logic [4:0] op;
    add_row(OP_ADD, Ones, 32'd1, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b0});
    add_row(OP_SUB, 32'd0, 32'd1, 1'b1, '{Ones, 6'd0, 1'b0, 1'b0});
    add_row(OP_MUL, Ones, Ones, 1'b1, '{32'd1, 6'd0, 1'b0, 1'b0});
    add_row(OP_DIVU, 32'd7, 32'd0, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b1});
    add_row(OP_MODU, Ones, 32'd0, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b1});
    add_row(OP_MULS, MinInt, Ones, 1'b0, '0);
    add_row(OP_DIVS, MinInt, Ones, 1'b1, '{MinInt, 6'd0, 1'b0, 1'b0});
    add_row(OP_MODS, MinInt, Ones, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b0});
    add_row(OP_DIVS, -32'sd7, 32'd2, 1'b0, '0);
    add_row(OP_MODS, -32'sd7, 32'd2, 1'b0, '0);
    add_row(OP_DIVS, 32'd5, 32'd0, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b1});
    add_row(OP_SHL1, Ones, 32'd0, 1'b0, '0);
    add_row(OP_SHR1, Ones, 32'd0, 1'b1, '{MaxInt, 6'd0, 1'b0, 1'b0});
    add_row(OP_SHL, Ones, 32'd32, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b0});
    add_row(OP_SHR, Ones, 32'd31, 1'b1, '{32'd1, 6'd0, 1'b0, 1'b0});
    add_row(OP_ROL1, MinInt, 32'd0, 1'b1, '{32'd1, 6'd0, 1'b0, 1'b0});
    add_row(OP_ROR1, 32'd1, 32'd0, 1'b1, '{MinInt, 6'd0, 1'b0, 1'b0});
    add_row(OP_ROL, 32'h1234_5678, 32'd36, 1'b0, '0);
    add_row(OP_ROR, 32'h1234_5678, Ones, 1'b0, '0);
    add_row(OP_BSET, 32'd0, 32'd32, 1'b1, '{32'd0, 6'd0, 1'b0, 1'b0});
    add_row(OP_BCLR, Ones, 32'd31, 1'b1, '{MaxInt, 6'd0, 1'b0, 1'b0});
    add_row(OP_CMP, 32'd5, 32'd5, 1'b1, '{32'd5, FLAG_EQ, 1'b1, 1'b0});
    add_row(OP_CMP, 32'd0, Ones, 1'b1, '{32'd0, FLAG_NE | FLAG_LT, 1'b1, 1'b0});
    add_row(OP_TSTZ, 32'd0, Ones, 1'b1, '{32'd0, FLAG_ZERO, 1'b1, 1'b0});
    add_row(5'd31, 32'hA5A5_A5A5, Ones, 1'b1, '{32'hA5A5_A5A5, 6'd0, 1'b0, 1'b0});
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      w = dir_rows[i].known ? dir_rows[i].want
                            : alu_predict(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
      pending_results.push_back(w);
      send_op(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b);
    end
    for (int i = 0; i < NumRandom; i++) begin
      // Hold off until the pipeline has drained, once in the middle.
      if (i == NumRandom / 2) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      g = (i % 300 < 60) ? 0 : gap_len();
      if (g != 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      op = ($urandom_range(15) == 0) ? 5'($urandom_range(31, 27))
                                     : 5'($urandom_range(OP_PASS));
      w = alu_predict(op, 0, 0);
      begin
        logic [Width-1:0] a;
        logic [Width-1:0] b;
        a = rand_word();
        b = ($urandom_range(3) == 0) ? 32'($urandom_range(40)) : rand_word();
        if (op == OP_CMP && $urandom_range(3) == 0) b = a;
        pending_results.push_back(alu_predict(op, a, b));
        send_op(op, a, b);
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Receiver stalls at random.
  initial begin
    int unsigned g;
    forever begin
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) || $urandom_range(2) != 0);
      g = (cycles % 5000 < 800) ? 0 : gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    alu_out_t w;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result transfer: %h", result);
      end else begin
        w = pending_results.pop_front();
        if (result !== w.res || flags !== w.flg || flags_valid !== w.fv ||
            divide_by_zero !== w.dz) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("result: exp %h/%h/%b/%b got %h/%h/%b/%b", w.res, w.flg, w.fv,
                     w.dz, result, flags, flags_valid, divide_by_zero);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_results.size() != 0 && cycles < Limit) @(posedge clk);
    repeat (80) @(posedge clk);
    if (cycles >= Limit) begin
      $display("cpu_integer_alu: mismatch");
    end else if (errors == 0 && pending_results.size() == 0) begin
      $display("cpu_integer_alu: match");
    end else begin
      $display("cpu_integer_alu: mismatch");
    end
    $finish;
  end

  initial begin
    wait (cycles >= Limit);
    $display("cpu_integer_alu: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
